// File: hdl/bdclp_pkg.sv
// Shared types and constants for the debounced button block.
// No dependencies; every other file in hdl/ but bdclp_checker refers to it by scoped names.
package bdclp_pkg;

  localparam int unsigned STAMP_W = 32;  // width of now_ms and of the time registers
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME = 2'd2;

  localparam logic [STAMP_W-1:0] DEBOUNCE_RESET   = 32'd50;
  localparam logic [STAMP_W-1:0] LONG_PRESS_RESET = 32'd1000;

  typedef struct packed {
    logic               raw_level;
    logic [STAMP_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic is_pressed;
    logic pressed_event;
    logic released_event;
    logic clicked_event;
    logic long_pressed_event;
  } result_t;

  typedef struct packed {
    logic               active_low;
    logic [STAMP_W-1:0] debounce_time;
    logic [STAMP_W-1:0] long_press_time;
  } cfg_t;

endpackage

// File: hdl/bdclp_if.sv
// Valid/ready channel interfaces: sample input, result output, register writes.
// Depends on bdclp_pkg for field widths.
interface bdclp_sample_if;
  logic                          valid;
  logic                          ready;
  logic                          raw_level;
  logic [bdclp_pkg::STAMP_W-1:0] now_ms;

  modport source (output valid, output raw_level, output now_ms, input ready);
  modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

interface bdclp_result_if;
  logic valid;
  logic ready;
  logic is_pressed;
  logic pressed_event;
  logic released_event;
  logic clicked_event;
  logic long_pressed_event;

  modport source (output valid, output is_pressed, output pressed_event,
                  output released_event, output clicked_event,
                  output long_pressed_event, input ready);
  modport sink   (input valid, input is_pressed, input pressed_event,
                  input released_event, input clicked_event,
                  input long_pressed_event, output ready);
endinterface

interface bdclp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bdclp_pkg::CFG_IDX_W-1:0] index;
  logic [bdclp_pkg::STAMP_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/button_debounce_click_long_press.sv
// A sample passes from the input register through the step logic to the output register.
// Throughput: one sample per cycle unless the result port stalls; one result per sample.
// A stalled result holds in the output register while the input register keeps one more sample.
// Reset (rst, synchronous, active high): empties both registers, clears button state,
// config to active_low=0, debounce_time=50, long_press_time=1000. Depends on bdclp_pkg, bdclp_if.
module button_debounce_click_long_press #(
  parameter int unsigned TIME_WIDTH = 32  // wrap width of time arithmetic, 16..64
) (
  input  logic                  clk,
  input  logic                  rst,
  bdclp_sample_if.sink          sample,
  bdclp_result_if.source        result,
  bdclp_cfg_if.sink             cfg
);

  // --- configuration: writes always taken, unmapped index ignored
  bdclp_pkg::cfg_t cfg_regs;

  assign cfg.ready = 1'b1;

  bdclp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  // --- pipeline control
  // in_reg holds one sample; it moves into the output register (and commits
  // the button state) whenever the output register is empty or being drained.
  logic               in_valid;
  bdclp_pkg::sample_t in_item;
  logic               out_valid;
  bdclp_pkg::result_t out_item;
  bdclp_pkg::result_t step_result;
  logic               advance;
  logic               take;

  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;
  assign take         = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      in_item.raw_level <= sample.raw_level;
      in_item.now_ms    <= sample.now_ms;
    end
  end

  // --- step logic and button state
  bdclp_eval #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_eval (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .sample (in_item),
    .cfg    (cfg_regs),
    .result (step_result)
  );

  // --- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_result;
    end
  end

  assign result.valid              = out_valid;
  assign result.is_pressed         = out_item.is_pressed;
  assign result.pressed_event      = out_item.pressed_event;
  assign result.released_event     = out_item.released_event;
  assign result.clicked_event      = out_item.clicked_event;
  assign result.long_pressed_event = out_item.long_pressed_event;

endmodule

// File: hdl/bdclp_cfg.sv
// Configuration register file: active_low, debounce_time, long_press_time.
// Depends on bdclp_pkg; written through the cfg channel (always ready).
module bdclp_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [bdclp_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [bdclp_pkg::STAMP_W-1:0]   wr_data,
  output bdclp_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_low      <= 1'b0;
      cfg.debounce_time   <= bdclp_pkg::DEBOUNCE_RESET;
      cfg.long_press_time <= bdclp_pkg::LONG_PRESS_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        bdclp_pkg::REG_ACTIVE_LOW:      cfg.active_low      <= wr_data[0];
        bdclp_pkg::REG_DEBOUNCE_TIME:   cfg.debounce_time   <= wr_data;
        bdclp_pkg::REG_LONG_PRESS_TIME: cfg.long_press_time <= wr_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

// File: hdl/bdclp_eval.sv
// Button state registers and the single-pass step logic (debounce, press,
// release, click, long press). Depends on bdclp_pkg.
module bdclp_eval #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,      // evaluate the registered sample and commit state
  input  bdclp_pkg::sample_t  sample,
  input  bdclp_pkg::cfg_t     cfg,
  output bdclp_pkg::result_t  result
);

  localparam int unsigned SW = bdclp_pkg::STAMP_W;

  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] deb_time;
  logic [TIME_WIDTH-1:0] lp_time;

  // fit 32-bit stamps and settings into the time width
  generate
    if (TIME_WIDTH > SW) begin : g_wide
      assign now      = {{(TIME_WIDTH-SW){1'b0}}, sample.now_ms};
      assign deb_time = {{(TIME_WIDTH-SW){1'b0}}, cfg.debounce_time};
      assign lp_time  = {{(TIME_WIDTH-SW){1'b0}}, cfg.long_press_time};
    end else if (TIME_WIDTH == SW) begin : g_same
      assign now      = sample.now_ms;
      assign deb_time = cfg.debounce_time;
      assign lp_time  = cfg.long_press_time;
    end else begin : g_narrow
      assign now      = sample.now_ms[TIME_WIDTH-1:0];
      assign deb_time = cfg.debounce_time[TIME_WIDTH-1:0];
      assign lp_time  = cfg.long_press_time[TIME_WIDTH-1:0];
    end
  endgenerate

  logic                  last_level;
  logic [TIME_WIDTH-1:0] level_change_time;
  logic                  stable_pressed;
  logic [TIME_WIDTH-1:0] press_start_time;
  logic                  long_press_armed;
  logic                  long_press_fired;

  logic                  last_level_next;
  logic [TIME_WIDTH-1:0] level_change_time_next;
  logic                  stable_pressed_next;
  logic [TIME_WIDTH-1:0] press_start_time_next;
  logic                  long_press_armed_next;
  logic                  long_press_fired_next;

  logic                  level;
  logic [TIME_WIDTH-1:0] deb_elapsed;
  logic [TIME_WIDTH-1:0] hold_elapsed;
  logic                  settle;
  logic                  ev_press;
  logic                  ev_release;
  logic                  ev_long;
  logic                  armed_mid;
  logic                  fired_mid;

  always_comb begin
    level = sample.raw_level ^ cfg.active_low;

    last_level_next        = level;
    level_change_time_next = (level != last_level) ? now : level_change_time;

    // wrapping difference
    deb_elapsed = now - level_change_time_next;
    settle      = (deb_elapsed >= deb_time) && (stable_pressed != level);

    ev_press   = settle && level;
    ev_release = settle && !level;

    stable_pressed_next   = settle ? level : stable_pressed;
    press_start_time_next = ev_press ? now : press_start_time;
    armed_mid             = ev_press ? 1'b1 : (ev_release ? 1'b0 : long_press_armed);
    fired_mid             = ev_release ? 1'b0 : long_press_fired;

    hold_elapsed = now - press_start_time_next;
    ev_long      = armed_mid && stable_pressed_next && (hold_elapsed >= lp_time);

    long_press_armed_next = ev_long ? 1'b0 : armed_mid;
    long_press_fired_next = ev_long ? 1'b1 : fired_mid;

    result.is_pressed         = stable_pressed_next;
    result.pressed_event      = ev_press;
    result.released_event     = ev_release;
    result.clicked_event      = ev_release && !long_press_fired;
    result.long_pressed_event = ev_long;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level        <= 1'b0;
      level_change_time <= '0;
      stable_pressed    <= 1'b0;
      press_start_time  <= '0;
      long_press_armed  <= 1'b0;
      long_press_fired  <= 1'b0;
    end else if (step) begin
      last_level        <= last_level_next;
      level_change_time <= level_change_time_next;
      stable_pressed    <= stable_pressed_next;
      press_start_time  <= press_start_time_next;
      long_press_armed  <= long_press_armed_next;
      long_press_fired  <= long_press_fired_next;
    end
  end

endmodule

// File: hdl/bdclp_checker.sv
// Port-level checks for button_debounce_click_long_press, bound to the top level.
// Depends only on the top-level ports.
module bdclp_props (
  input logic clk,
  input logic rst,
  input logic s_ready,
  input logic r_valid,
  input logic r_ready,
  input logic is_pressed,
  input logic pressed_event,
  input logic released_event,
  input logic clicked_event,
  input logic long_pressed_event
);

  // stalled result transaction keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(is_pressed) && $stable(pressed_event)
      && $stable(released_event) && $stable(clicked_event) && $stable(long_pressed_event))
    else $error("result changed while stalled");

  // output register empties on reset
  a_rst: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !r_valid)
    else $error("result valid right after reset");

  // an empty output side never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !r_valid |-> s_ready)
    else $error("input stalled with output empty");

  // event flags agree with the stable state
  a_press: assert property (@(posedge clk) disable iff (rst)
    r_valid && (pressed_event || long_pressed_event) |-> is_pressed && !released_event)
    else $error("press event without pressed state");

  a_release: assert property (@(posedge clk) disable iff (rst)
    r_valid && (released_event || clicked_event) |-> !is_pressed && released_event)
    else $error("release or click inconsistent");

endmodule

bind button_debounce_click_long_press bdclp_props u_bdclp_props (
  .clk                (clk),
  .rst                (rst),
  .s_ready            (sample.ready),
  .r_valid            (result.valid),
  .r_ready            (result.ready),
  .is_pressed         (result.is_pressed),
  .pressed_event      (result.pressed_event),
  .released_event     (result.released_event),
  .clicked_event      (result.clicked_event),
  .long_pressed_event (result.long_pressed_event)
);

// File: sim/bdclp_checker.sv
`timescale 1ns / 100ps
// Result checker for the debounced button block: watches the sample, result and
// register channels, predicts every result and compares it field by field.
// Depends on bdclp_pkg and the channel interfaces of bdclp_if.
module bdclp_checker (
  input  logic        clk,
  input  logic        rst,
  bdclp_sample_if     sample,
  bdclp_result_if     result,
  bdclp_cfg_if        cfg,
  output int unsigned mismatches,
  output int unsigned in_flight
);
  import bdclp_pkg::*;

  typedef logic [STAMP_W-1:0] stamp_t;

  // register shadow
  logic   inv_level;
  stamp_t settle_ms;
  stamp_t hold_ms;

  // button state
  logic   seen_level;
  stamp_t seen_since;
  logic   btn_down;
  stamp_t down_since;
  logic   long_armed;
  logic   long_done;

  result_t     button_log[$];
  result_t     want;
  int unsigned err_cnt = 0;

  function automatic result_t advance_button(input logic raw, input stamp_t now);
    result_t r;
    logic    lvl;
    stamp_t  since_change;
    stamp_t  since_down;
    r   = '0;
    lvl = raw ^ inv_level;
    if (lvl != seen_level) begin
      seen_level = lvl;
      seen_since = now;
    end
    since_change = now - seen_since;  // wraps at STAMP_W
    if (since_change >= settle_ms && btn_down != lvl) begin
      btn_down = lvl;
      if (lvl) begin
        r.pressed_event = 1'b1;
        down_since      = now;
        long_armed      = 1'b1;
      end else begin
        r.released_event = 1'b1;
        r.clicked_event  = !long_done;
        long_done        = 1'b0;
        long_armed       = 1'b0;
      end
    end
    since_down = now - down_since;
    if (long_armed && btn_down && since_down >= hold_ms) begin
      r.long_pressed_event = 1'b1;
      long_armed           = 1'b0;
      long_done            = 1'b1;
    end
    r.is_pressed = btn_down;
    return r;
  endfunction

  function automatic int unsigned field_bad(input string name, input logic exp_v,
                                            input logic got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0b, got %0b", name, exp_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      inv_level  = 1'b0;
      settle_ms  = DEBOUNCE_RESET;
      hold_ms    = LONG_PRESS_RESET;
      seen_level = 1'b0;
      seen_since = '0;
      btn_down   = 1'b0;
      down_since = '0;
      long_armed = 1'b0;
      long_done  = 1'b0;
      button_log.delete();
    end else begin
      // results first: a result never belongs to a sample taken at the same edge
      if (result.valid && result.ready) begin
        if (button_log.size() == 0) begin
          $error("result transaction with no sample outstanding");
          err_cnt++;
        end else begin
          want = button_log.pop_front();
          err_cnt += field_bad("is_pressed", want.is_pressed, result.is_pressed);
          err_cnt += field_bad("pressed_event", want.pressed_event, result.pressed_event);
          err_cnt += field_bad("released_event", want.released_event,
                               result.released_event);
          err_cnt += field_bad("clicked_event", want.clicked_event, result.clicked_event);
          err_cnt += field_bad("long_pressed_event", want.long_pressed_event,
                               result.long_pressed_event);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ACTIVE_LOW:      inv_level = cfg.data[0];
          REG_DEBOUNCE_TIME:   settle_ms = cfg.data;
          REG_LONG_PRESS_TIME: hold_ms   = cfg.data;
          default: ;
        endcase
      end
      if (sample.valid && sample.ready)
        button_log.push_back(advance_button(sample.raw_level, sample.now_ms));
    end
    mismatches <= err_cnt;
    in_flight  <= button_log.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the debounced button testbench: clock, reset, sample and register
// stimulus, result back-pressure and the verdict. Depends on bdclp_pkg,
// bdclp_if, the block itself and bdclp_checker.
module tb_top;
  import bdclp_pkg::*;

  typedef logic [STAMP_W-1:0] stamp_t;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst;

  bdclp_sample_if sample_ch ();
  bdclp_result_if result_ch ();
  bdclp_cfg_if    cfg_ch ();

  int unsigned mismatches;
  int unsigned in_flight;

  button_debounce_click_long_press uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  bdclp_checker chk (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample_ch),
    .result     (result_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  int unsigned cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side back-pressure. Runs of ready-high, short stalls and the odd
  // long stall, so the output register gets held on every phase of the work.
  int unsigned rx_left = 0;
  int unsigned rx_pick;
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_left         <= 0;
    end else if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 55) begin
        result_ch.ready <= 1'b1;
        rx_left         <= $urandom_range(0, 24);
      end else if (rx_pick < 92) begin
        result_ch.ready <= 1'b0;
        rx_left         <= $urandom_range(0, 2);
      end else begin
        result_ch.ready <= 1'b0;
        rx_left         <= $urandom_range(8, 40);
      end
    end
  end

  // Sender side state
  logic   burst;   // no gaps at all while set
  stamp_t stamp;   // running millisecond time base

  function automatic int unsigned idle_gap();
    int unsigned pick;
    if (burst)
      return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      return 0;
    if (pick < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One poll transaction. valid stays high from one accepted poll to the
  // next unless a gap is inserted, so it is never lowered and raised in one step.
  task automatic send_poll(input logic lvl, input stamp_t t);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.raw_level <= lvl;
    sample_ch.now_ms    <= t;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // Stop sending and wait for every outstanding result. The extra edge lets
  // the checker's count include a sample accepted at the current edge.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input stamp_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Registers only change with the block idle.
  task automatic set_config(input logic al, input stamp_t settle, input stamp_t hold);
    drain();
    put_reg(REG_ACTIVE_LOW, stamp_t'(al));
    put_reg(REG_DEBOUNCE_TIME, settle);
    put_reg(REG_LONG_PRESS_TIME, hold);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random press/release episodes: optional contact bounce, then the level
  // held for a while with time moving forward. A few polls are noise with an
  // arbitrary timestamp, which also makes time jump backwards or wrap.
  task automatic run_phase(input int unsigned n_items, input stamp_t step_max);
    int unsigned sent;
    int unsigned kind;
    int unsigned reps;
    logic        lvl;
    logic        bounce;
    logic        drained;
    stamp_t      t;
    sent    = 0;
    drained = 1'b0;
    while (sent < n_items) begin
      burst = ($urandom_range(0, 4) == 0);
      kind  = $urandom_range(0, 99);
      if (kind < 8) begin
        t = $urandom;
        if (kind < 4)
          stamp = t;
        send_poll(1'($urandom_range(0, 1)), t);
        sent++;
      end else begin
        lvl    = 1'($urandom_range(0, 1));
        bounce = ~lvl;
        reps   = $urandom_range(0, 4);
        repeat (reps) begin
          stamp += $urandom_range(0, step_max / 4 + 1);
          send_poll(bounce, stamp);
          bounce = ~bounce;
          sent++;
        end
        reps = $urandom_range(1, 16);
        repeat (reps) begin
          stamp += $urandom_range(0, step_max);
          send_poll(lvl, stamp);
          sent++;
        end
      end
      // sender holds off once per phase until the pipe is empty
      if (!drained && sent >= n_items / 2) begin
        drain();
        drained = 1'b1;
      end
    end
  endtask

  logic        ph_al;
  stamp_t      ph_settle;
  stamp_t      ph_hold;
  stamp_t      ph_step;
  int unsigned ph_items;

  initial begin
    rst                 <= 1'b1;
    burst               = 1'b0;
    stamp               = '0;
    sample_ch.valid     <= 1'b0;
    sample_ch.raw_level <= 1'b0;
    sample_ch.now_ms    <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_ACTIVE_LOW;
    cfg_ch.data         <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset config (debounce 50, long press 1000, active high).
    // Pin already high out of reset: debounce starts at the first sample.
    send_poll(1'b1, 32'd100);
    send_poll(1'b1, 32'd150);    // press
    send_poll(1'b1, 32'd1149);   // one ms short of the long press
    send_poll(1'b1, 32'd1150);   // long press
    send_poll(1'b0, 32'd1200);
    send_poll(1'b0, 32'd1250);   // release after long press: no click
    send_poll(1'b1, 32'd1300);
    send_poll(1'b1, 32'd1350);   // press
    send_poll(1'b0, 32'd1400);
    send_poll(1'b0, 32'd1450);   // release with click
    send_poll(1'b1, 32'd2000);
    send_poll(1'b1, 32'd1999);   // time steps back: wrapped delta counts as elapsed
    send_poll(1'b0, 32'hFFFF_FFF0);
    send_poll(1'b0, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'h0000_0000);
    send_poll(1'b0, 32'h0000_0021);  // 49 ms across the wrap
    send_poll(1'b0, 32'h0000_0022);  // 50 ms across the wrap

    // Active low, zero debounce, zero long press: new level adopted at once,
    // press and long press in the same poll.
    set_config(1'b1, '0, '0);
    send_poll(1'b0, 32'd5);
    send_poll(1'b1, 32'd6);
    send_poll(1'b0, 32'd7);

    // Both times at their maximum: only a one ms step back reaches them.
    set_config(1'b0, '1, '1);
    send_poll(1'b0, 32'd1000);
    send_poll(1'b0, 32'd999);
    send_poll(1'b1, 32'd50);
    send_poll(1'b1, 32'd49);
    send_poll(1'b1, 32'd48);

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 5; ph++) begin
      ph_al    = 1'($urandom_range(0, 1));
      ph_items = 140;
      case (ph)
        0: begin
          ph_settle = $urandom_range(1, 20);
          ph_hold   = $urandom_range(20, 200);
        end
        1: begin
          ph_settle = '0;
          ph_hold   = $urandom_range(0, 60);
        end
        2: begin
          ph_settle = $urandom_range(1, 40);
          ph_hold   = '0;
        end
        3: begin
          ph_settle = $urandom_range(0, 100);
          ph_hold   = $urandom_range(100, 2000);
        end
        default: begin
          ph_settle = $urandom;
          ph_hold   = $urandom;
          ph_items  = 60;
        end
      endcase
      if (ph == 4)
        ph_step = '1;  // arbitrary leaps, wrap included
      else
        ph_step = ph_settle / 2 + ph_hold / 8 + 3;
      set_config(ph_al, ph_settle, ph_hold);
      stamp = $urandom;
      run_phase(ph_items, ph_step);
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
